@@ rtl/core/lsbsteg_pkg.sv @@
// Package for the LSB steganography pixel embedder: command codes, header
// size, bit-position width, default store depth and register address.
// No dependencies.
`timescale 1ns / 1ps

package lsbsteg_pkg;

  // Command codes carried in the command field of an input transfer.
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdPixel = 1'b1;

  // The message length header is always fifteen bits, sent MSB first.
  localparam int HeaderBits = 15;

  // Width of the message length register and of the bit position counter.
  localparam int MsgLenW = 13;
  localparam int PosW    = 16;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // Default number of bytes in the message store.
  localparam int MsgDepthDefault = 4096;

  // Byte address of the message length register on the configuration port.
  localparam logic [2:0] RegMsgLenAddr = 3'd0;

endpackage

@@ rtl/core/lsb_stego_pixel_embedder.sv @@
// Top level of the LSB steganography pixel embedder: message store, bit
// position tracking, two-stage pixel path and configuration port.
// Depends on lsbsteg_pkg.
`timescale 1ns / 1ps

// The block hides a message in the least significant bits of a BGR pixel
// stream. Message bytes are first written into the store with load
// transfers (command 0); each pixel transfer (command 1) then has its blue,
// green and red channels, in that order, take one bit slot each. The first
// fifteen slots carry the message length, MSB first, and the following
// length*8 slots carry the message bytes in ascending store order, MSB first
// within each byte; channels beyond the last bit pass unchanged. Setting
// frame_start on a pixel restarts the slot count at zero. One transfer is
// accepted in every clock cycle, loads and pixels alike, unless stage one
// is occupied while the output stalls. A pixel's result is formed by the
// registered read of the two store bytes that the pixel's slots can touch,
// then by the bit insertion into the output register. Loads produce no
// result. The store has no reset; only bytes that have been loaded may fall
// within the programmed length. The message length register at byte address
// 0 must only be written while no pixel is in flight.
module lsb_stego_pixel_embedder #(
  parameter int MSG_DEPTH = lsbsteg_pkg::MsgDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // Input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [11:0] message_index_i,
  input  logic [7:0]  message_byte_i,
  input  logic        frame_start_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,

  // Output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  red_out_o,
  output logic        embedding_done_o
);

  localparam int PosW    = lsbsteg_pkg::PosW;
  localparam int MsgLenW = lsbsteg_pkg::MsgLenW;
  localparam int AW      = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam logic [PosW-1:0] DepthW  = PosW'(MSG_DEPTH);
  localparam logic [PosW-1:0] HdrPos  = PosW'(lsbsteg_pkg::HeaderBits);
  localparam logic [PosW:0]   HdrSlot = (PosW+1)'(lsbsteg_pkg::HeaderBits);

  // ---------------------------------------------------------------------
  // Configuration register. Any write whose word address is zero lands in
  // the message length register; other addresses are ignored.
  // ---------------------------------------------------------------------
  logic [MsgLenW-1:0] msg_len_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == lsbsteg_pkg::RegMsgLenAddr[2]);
  assign prdata = (paddr[2] == lsbsteg_pkg::RegMsgLenAddr[2]) ?
                  {{(32-MsgLenW){1'b0}}, msg_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q <= '0;
    end else if (cfg_wr) begin
      msg_len_q <= pwdata[MsgLenW-1:0];
    end
  end

  // The effective length never exceeds the store depth; it feeds both the
  // header and the count of embedded message bits.
  logic [PosW-1:0]    len_cmp;
  logic [MsgLenW-1:0] eff_len;
  logic [PosW-1:0]    msg_bits;

  assign len_cmp  = ({{(PosW-MsgLenW){1'b0}}, msg_len_q} > DepthW) ?
                    DepthW : {{(PosW-MsgLenW){1'b0}}, msg_len_q};
  assign eff_len  = len_cmp[MsgLenW-1:0];
  assign msg_bits = {eff_len, 3'b000};

  // ---------------------------------------------------------------------
  // Handshake. Stage one holds a pixel whose store bytes are being read,
  // the output register holds a finished result. A stalled output only
  // blocks new transfers once stage one is also occupied.
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_advance;
  logic in_accept;
  logic pix_accept;
  logic load_accept;

  assign s1_advance  = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s1_advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign pix_accept  = in_accept && (command_i == lsbsteg_pkg::CmdPixel);
  assign load_accept = in_accept && (command_i == lsbsteg_pkg::CmdLoad);
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------
  // Bit position. The pixel starts at slot zero when it opens a frame,
  // and the counter saturates at its top value on a long stream.
  // ---------------------------------------------------------------------
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] p_start;
  logic [PosW:0]   pos_sum;

  assign p_start = frame_start_i ? '0 : pos_q;
  assign pos_sum = {1'b0, p_start} + (PosW+1)'(3);
  assign pos_d   = pos_sum[PosW] ? lsbsteg_pkg::PosMax : pos_sum[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (pix_accept) begin
      pos_q <= pos_d;
    end
  end

  // ---------------------------------------------------------------------
  // Message store. Three consecutive slots touch at most two adjacent
  // bytes, so two read ports cover a whole pixel.
  // ---------------------------------------------------------------------
  logic [7:0]      msg_mem [MSG_DEPTH];
  logic [PosW-1:0] wr_idx;
  logic [PosW-1:0] first_msg;
  logic [PosW-1:0] rd_idx0, rd_idx1;
  logic [7:0]      rd0_q, rd1_q;

  assign wr_idx    = {{(PosW-12){1'b0}}, message_index_i};
  assign first_msg = (p_start < HdrPos) ? '0 : (p_start - HdrPos);
  assign rd_idx0   = first_msg >> 3;
  assign rd_idx1   = rd_idx0 + PosW'(1);

  always_ff @(posedge clk_i) begin
    if (load_accept && (wr_idx < DepthW)) begin
      msg_mem[wr_idx[AW-1:0]] <= message_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      rd0_q <= msg_mem[rd_idx0[AW-1:0]];
      rd1_q <= msg_mem[rd_idx1[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------
  // Stage one register: the pixel, its first slot, its lower byte index
  // and the bit position that follows it.
  // ---------------------------------------------------------------------
  logic [7:0]      s1_blue_q, s1_green_q, s1_red_q;
  logic [PosW-1:0] s1_pos_q, s1_next_q;
  logic [13:0]     s1_idx0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= pix_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      s1_blue_q  <= blue_in_i;
      s1_green_q <= green_in_i;
      s1_red_q   <= red_in_i;
      s1_pos_q   <= p_start;
      s1_next_q  <= pos_d;
      s1_idx0_q  <= rd_idx0[13:0];
    end
  end

  // ---------------------------------------------------------------------
  // Bit insertion. A slot inside the header takes a length bit, a slot
  // inside the message takes a bit of one of the two fetched bytes, and
  // any later slot leaves the channel untouched.
  // ---------------------------------------------------------------------
  logic [14:0] hdr_bits;
  assign hdr_bits = {{(15-MsgLenW){1'b0}}, eff_len};

  function automatic logic [7:0] embed_chan(
    input logic [7:0]    chan,
    input logic [PosW:0] slot,
    input logic [PosW:0] bits_lim,
    input logic [14:0]   hdr,
    input logic [13:0]   idx0,
    input logic [7:0]    byte0,
    input logic [7:0]    byte1
  );
    logic [PosW:0] m;
    logic [7:0]    src;
    logic [7:0]    res;
    res = chan;
    m   = slot - HdrSlot;
    src = (m[PosW:3] == idx0) ? byte0 : byte1;
    if (slot < HdrSlot) begin
      res[0] = hdr[4'(lsbsteg_pkg::HeaderBits - 1) - slot[3:0]];
    end else if (m < bits_lim) begin
      res[0] = src[3'd7 - m[2:0]];
    end
    return res;
  endfunction

  logic [PosW:0] slot0;
  logic [PosW:0] bits_lim;
  logic [PosW:0] total_slots;
  logic [7:0]    blue_d, green_d, red_d;
  logic          done_d;

  assign slot0       = {1'b0, s1_pos_q};
  assign bits_lim    = {1'b0, msg_bits};
  assign total_slots = HdrSlot + bits_lim;

  assign blue_d  = embed_chan(s1_blue_q, slot0, bits_lim, hdr_bits,
                              s1_idx0_q, rd0_q, rd1_q);
  assign green_d = embed_chan(s1_green_q, slot0 + (PosW+1)'(1), bits_lim,
                              hdr_bits, s1_idx0_q, rd0_q, rd1_q);
  assign red_d   = embed_chan(s1_red_q, slot0 + (PosW+1)'(2), bits_lim,
                              hdr_bits, s1_idx0_q, rd0_q, rd1_q);
  assign done_d  = ({1'b0, s1_next_q} >= total_slots);

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  logic [7:0] blue_q, green_q, red_q;
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
      done_q  <= done_d;
    end
  end

  assign blue_out_o       = blue_q;
  assign green_out_o      = green_q;
  assign red_out_o        = red_q;
  assign embedding_done_o = done_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A pixel that opens a frame leaves the counter three slots on.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_accept && frame_start_i) |=> (pos_q == PosW'(3)))
    else $error("bit position not restarted by frame start");

  // Loads never move the bit position.
  a_load_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_accept |=> $stable(pos_q))
    else $error("bit position changed by a load transfer");

  // A pixel held in stage one is not dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_advance) |=> s1_valid_q)
    else $error("stage one pixel lost under output stall");

  // With either stage free the block must take a new transfer.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_valid_q || !out_valid_q) |-> in_ready_o)
    else $error("input stalled with free pipeline space");

  // Every pixel in stage one reaches the output register when it moves.
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_advance) |=> out_valid_q)
    else $error("pixel result not delivered to the output register");

endmodule

@@ tb/lsb_stego_pixel_checker.sv @@
// Scoreboard for the LSB steganography pixel embedder: mirrors the message
// store, the length register and the bit position, and checks each pixel result.
// Depends on lsbsteg_pkg.
`timescale 1ns / 1ps

module lsb_stego_pixel_checker #(
  parameter int MSG_DEPTH = lsbsteg_pkg::MsgDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration port, watched for writes only.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,

  // Input channel.
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        command_i,
  input  logic [11:0] message_index_i,
  input  logic [7:0]  message_byte_i,
  input  logic        frame_start_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,

  // Output channel.
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  blue_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  red_out_i,
  input  logic        embedding_done_i,

  output int          mismatches_o,
  output int          pending_o,
  output int          pixels_checked_o,
  output int          loads_seen_o
);

  localparam int MsgLenW    = lsbsteg_pkg::MsgLenW;
  localparam int HeaderBits = lsbsteg_pkg::HeaderBits;
  localparam int unsigned PosMax = lsbsteg_pkg::PosMax;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       done;
  } stego_pixel_t;

  logic [7:0]         store_mirror [MSG_DEPTH];
  logic [MsgLenW-1:0] length_reg = '0;
  int unsigned        slot_pos = 0;
  stego_pixel_t       stego_pixel_q [$];
  int                 mismatches = 0;
  int                 pixels_checked = 0;
  int                 loads_seen = 0;

  function automatic int unsigned live_length();
    return (length_reg > MSG_DEPTH) ? MSG_DEPTH : length_reg;
  endfunction

  // Puts the bit that falls on this slot into the channel LSB. A slot past
  // the last message bit leaves the channel untouched.
  function automatic logic [7:0] stego_channel(logic [7:0] chan, int unsigned slot,
                                               int unsigned len);
    logic [31:0] header;
    int unsigned msg_slot;
    logic [7:0]  res;
    header = len;
    res    = chan;
    if (slot < HeaderBits) begin
      res[0] = header[HeaderBits - 1 - slot];
    end else begin
      msg_slot = slot - HeaderBits;
      if (msg_slot < len * 8 && (msg_slot >> 3) < MSG_DEPTH) begin
        res[0] = store_mirror[msg_slot >> 3][7 - (msg_slot & 7)];
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stego_pixel_t want;
    int unsigned  len;
    int unsigned  next_pos;
    if (!rst_ni) begin
      length_reg = '0;
      slot_pos   = 0;
      stego_pixel_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[2] == lsbsteg_pkg::RegMsgLenAddr[2]) begin
        length_reg = pwdata_i[MsgLenW-1:0];
      end

      if (out_valid_i && out_ready_i) begin
        if (stego_pixel_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected pixel result, expected none, got %02h %02h %02h done %0b",
                   $time, blue_out_i, green_out_i, red_out_i, embedding_done_i);
        end else begin
          want = stego_pixel_q.pop_front();
          check_field("blue", want.blue, blue_out_i);
          check_field("green", want.green, green_out_i);
          check_field("red", want.red, red_out_i);
          check_field("embedding_done", {7'd0, want.done}, {7'd0, embedding_done_i});
          pixels_checked++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (command_i == lsbsteg_pkg::CmdLoad) begin
          if (message_index_i < MSG_DEPTH) begin
            store_mirror[message_index_i] = message_byte_i;
          end
          loads_seen++;
        end else begin
          if (frame_start_i) begin
            slot_pos = 0;
          end
          len        = live_length();
          want.blue  = stego_channel(blue_in_i, slot_pos, len);
          want.green = stego_channel(green_in_i, slot_pos + 1, len);
          want.red   = stego_channel(red_in_i, slot_pos + 2, len);
          next_pos   = (slot_pos + 3 > PosMax) ? PosMax : slot_pos + 3;
          slot_pos   = next_pos;
          want.done  = (next_pos >= HeaderBits + len * 8);
          stego_pixel_q.push_back(want);
        end
      end
    end
    mismatches_o     <= mismatches;
    pending_o        <= stego_pixel_q.size();
    pixels_checked_o <= pixels_checked;
    loads_seen_o     <= loads_seen;
  end

endmodule

@@ tb/lsb_stego_pixel_embedder_tb.sv @@
// Top level of the embedder testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict.
// Depends on lsbsteg_pkg, lsb_stego_pixel_embedder and lsb_stego_pixel_checker.
`timescale 1ns / 1ps

module lsb_stego_pixel_embedder_tb;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 7;
  localparam int MsgDepth     = lsbsteg_pkg::MsgDepthDefault;
  localparam int MsgLenW      = lsbsteg_pkg::MsgLenW;
  localparam int HeaderBits   = lsbsteg_pkg::HeaderBits;
  // Longest correct pause between transfers is a sender gap plus a short
  // receiver stall, the pipeline and a register write.
  localparam int IdleLimit    = 1000;
  localparam int SettleCycles = 4;
  localparam int RandomPhases = 10;
  localparam int PhaseItems   = 115;
  // Every phase opens a fresh frame, so no pixel reaches beyond byte 41 of
  // the store; the entries below this bound are written before any pixel.
  localparam int InitLoads    = 64;
  localparam logic [MsgLenW-1:0] LenMax = {MsgLenW{1'b1}};

  typedef enum int {
    ReadyAlways,
    ReadyCoinToss,
    ReadyOneInFour,
    ReadyMostly
  } ready_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic        command_i       = lsbsteg_pkg::CmdLoad;
  logic [11:0] message_index_i = '0;
  logic [7:0]  message_byte_i  = '0;
  logic        frame_start_i   = 1'b0;
  logic [7:0]  blue_in_i       = '0;
  logic [7:0]  green_in_i      = '0;
  logic [7:0]  red_in_i        = '0;

  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  blue_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  red_out_o;
  logic        embedding_done_o;

  int          mismatches;
  int          pending;
  int          pixels_checked;
  int          loads_seen;

  int          burst_left    = 0;
  bit          gap_free      = 1'b0;
  int          settings_used = 0;
  int          idle_cycles   = 0;
  int          ready_span    = 0;
  int          ready_tick    = 0;
  ready_mode_e ready_mode    = ReadyAlways;

  always #(HalfPeriod) clk_i = ~clk_i;

  lsb_stego_pixel_embedder #(
    .MSG_DEPTH(MsgDepth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .message_index_i (message_index_i),
    .message_byte_i  (message_byte_i),
    .frame_start_i   (frame_start_i),
    .blue_in_i       (blue_in_i),
    .green_in_i      (green_in_i),
    .red_in_i        (red_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blue_out_o      (blue_out_o),
    .green_out_o     (green_out_o),
    .red_out_o       (red_out_o),
    .embedding_done_o(embedding_done_o)
  );

  // The checker sees every transfer on both channels and every register
  // write, predicts each pixel result and reports mismatches back here.
  lsb_stego_pixel_checker #(
    .MSG_DEPTH(MsgDepth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .command_i       (command_i),
    .message_index_i (message_index_i),
    .message_byte_i  (message_byte_i),
    .frame_start_i   (frame_start_i),
    .blue_in_i       (blue_in_i),
    .green_in_i      (green_in_i),
    .red_in_i        (red_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blue_out_i      (blue_out_o),
    .green_out_i     (green_out_o),
    .red_out_i       (red_out_o),
    .embedding_done_i(embedding_done_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .pixels_checked_o(pixels_checked),
    .loads_seen_o    (loads_seen)
  );

  // The receiver switches its behaviour at random intervals: always
  // ready, a coin toss each cycle, one cycle in four, or ready with only an
  // occasional stall. Back-pressure therefore lands on every pipeline stage.
  always @(posedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_span = $urandom_range(8, 64);
    end else begin
      ready_span--;
    end
    ready_tick++;
    case (ready_mode)
      ReadyAlways:    out_ready_i <= 1'b1;
      ReadyCoinToss:  out_ready_i <= 1'($urandom_range(0, 1));
      ReadyOneInFour: out_ready_i <= (ready_tick % 4 == 0);
      default:        out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog: a correct block never goes this long without a transfer on
  // either channel while stimulus or results are outstanding.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: no transfer for %0d cycles, giving up", $time, IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Presents one item and holds it until the block takes it. The sender
  // works in bursts; between bursts valid drops for a random gap, unless
  // the current phase runs without gaps.
  task automatic send_item(logic cmd, logic [11:0] idx, logic [7:0] data, logic fs,
                           logic [7:0] b, logic [7:0] g, logic [7:0] r);
    if (burst_left == 0) begin
      if (!gap_free) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    message_index_i <= idx;
    message_byte_i  <= data;
    frame_start_i   <= fs;
    blue_in_i       <= b;
    green_in_i      <= g;
    red_in_i        <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // A load carries random pixel fields and frame_start, which the block
  // must ignore.
  task automatic load_byte(logic [11:0] idx, logic [7:0] data);
    send_item(lsbsteg_pkg::CmdLoad, idx, data, 1'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic send_pixel(logic fs, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    send_item(lsbsteg_pkg::CmdPixel, 12'($urandom), 8'($urandom), fs, b, g, r);
  endtask

  task automatic random_pixel(logic fs);
    send_pixel(fs, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Waits until every pixel result has come back, then a settling wait so
  // that a trailing load, which yields no result, has left the pipeline too.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The length register may only change with the block idle: drain first,
  // then a setup cycle and an access cycle on the configuration port.
  task automatic set_length(logic [MsgLenW-1:0] len);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lsbsteg_pkg::RegMsgLenAddr;
    pwdata  <= 32'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [MsgLenW-1:0] len;
    int unsigned        eff;
    int unsigned        frame_len;
    int unsigned        sent;
    bit                 phase_open;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The store has no reset, so every entry that a pixel of this run can
    // reach is written once before any pixel is sent. Later loads only
    // overwrite or land in entries that no pixel reads.
    for (int i = 0; i < InitLoads; i++) begin
      load_byte(12'(i), 8'($urandom));
    end

    // Length zero, the reset value: five pixels carry a header of fifteen
    // zero bits, with channel values at both extremes, and the sixth pixel
    // passes unchanged.
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'hFE, 8'h01, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_pixel(1'b0, 8'h55, 8'hAA, 8'h01);

    // Loads at both ends of the address range.
    load_byte(12'hFFF, 8'hFF);
    load_byte(12'h000, 8'h00);
    load_byte(12'h001, 8'hFF);

    // One message byte: 23 slots over eight pixels. The frame restarts after
    // two pixels, and byte zero is rewritten immediately ahead of the pixel
    // that embeds its first bits, so the store read has to see the new value.
    set_length(13'd1);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
    for (int k = 0; k < 4; k++) begin
      send_pixel(1'b0, {8{k[0]}}, {8{~k[0]}}, {8{k[0]}});
    end
    load_byte(12'h000, 8'h5A);
    send_pixel(1'b0, 8'h00, 8'hFF, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);

    // A length equal to the store depth, then the largest register value,
    // whose header must be clipped to the store depth.
    set_length(13'(MsgDepth));
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);
    set_length(LenMax);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF);

    // Random phases. Each one sets a length, mostly small so that whole
    // frames run to completion, and sends frames that normally open with
    // frame_start and run a little past the last message bit. The first
    // frame of a phase always opens with a restart. Loads are mixed in,
    // mostly into the part of the store being embedded, and a stray restart
    // or a later frame without a start marker now and then adds noise.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 0) begin
        len = '0;
      end else begin
        case ($urandom_range(0, 9))
          0:       len = '0;
          1:       len = 13'(MsgDepth);
          2:       len = LenMax;
          3, 4:    len = 13'($urandom_range(41, 160));
          default: len = 13'($urandom_range(1, 40));
        endcase
      end
      set_length(len);
      gap_free   = ($urandom_range(0, 3) == 0);
      eff        = (len > MsgDepth) ? MsgDepth : len;
      sent       = 0;
      phase_open = 1'b1;
      while (sent < PhaseItems) begin
        frame_len = (HeaderBits + eff * 8 + 2) / 3 + $urandom_range(0, 4);
        for (int k = 0; k < frame_len && sent < PhaseItems; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            if (eff > 0 && $urandom_range(0, 2) != 0) begin
              load_byte(12'($urandom_range(0, eff - 1)), 8'($urandom));
            end else begin
              load_byte(12'($urandom_range(0, MsgDepth - 1)), 8'($urandom));
            end
            sent++;
          end
          if (k == 0) begin
            random_pixel(phase_open || ($urandom_range(0, 9) != 0));
            phase_open = 1'b0;
          end else begin
            random_pixel($urandom_range(0, 49) == 0);
          end
          sent++;
        end
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d pixel results against %0d message byte loads under %0d settings",
             pixels_checked, loads_seen, settings_used);
    $display("of the length register, from an empty message up to the clipped maximum.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
